[design/md5_block_compression_unit_macros.svh]
// Assertion macros shared by the MD5 compression unit RTL.
`ifndef MD5_BLOCK_COMPRESSION_UNIT_MACROS_SVH
`define MD5_BLOCK_COMPRESSION_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// expr must hold on every clock edge out of reset
`define MD5_ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("invariant violated");

// cond implies prop in the same cycle
`define MD5_ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("implication violated");

// cond implies prop in the next cycle
`define MD5_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("next-cycle implication violated");

`else

`define MD5_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define MD5_ASSERT_IMPLIES(label, clk, rst_n, cond, prop)
`define MD5_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

[design/md5_pkg.sv]
// Package: MD5 constants, round helper functions and controller/datapath interface types.
`default_nettype none

package md5_pkg;

  localparam logic [31:0] IV [0:3] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  localparam logic [31:0] ROUND_K [0:63] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // rotate amounts indexed by {phase, round[1:0]}
  localparam logic [4:0] ROT_S [0:15] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  localparam int unsigned NUM_WORDS  = 16;
  localparam int unsigned NUM_ROUNDS = 64;

  typedef logic [$clog2(NUM_WORDS)-1:0]  word_idx_t;
  typedef logic [$clog2(NUM_ROUNDS)-1:0] round_t;

  // controller -> datapath
  typedef struct packed {
    logic      load_word;  // write one message word
    word_idx_t word_idx;
    logic      start_iv;   // reload chaining value with IV
    logic      init_work;  // copy chaining value into A..D
    logic      kw_load;    // prefetch K + M for round kw_round
    round_t    kw_round;
    logic      do_round;   // run one round step
    round_t    round;
    logic      finish;     // fold A..D into chain, load result beat
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_busy;
  } status_t;

  // message word index for a round
  function automatic word_idx_t msg_index(input round_t r);
    word_idx_t lo;
    word_idx_t g;
    lo = r[3:0];
    case (r[5:4])
      2'd0:    g = lo;
      2'd1:    g = 4'd5 * lo + 4'd1;
      2'd2:    g = 4'd3 * lo + 4'd5;
      default: g = 4'd7 * lo;
    endcase
    return g;
  endfunction

  function automatic logic [31:0] round_f(input round_t r, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    case (r[5:4])
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (b & d) | (c & ~d);
      2'd2:    f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    return f;
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] t;
    t = {x, x} << s;
    return t[63:32];
  endfunction

endpackage

`default_nettype wire

[design/md5_datapath.sv]
// Datapath: block word store, chaining value, round registers and result register.
`default_nettype none

module md5_datapath (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire md5_pkg::cmd_t   cmd_i,
  input  wire logic [31:0]     word_i,
  input  wire logic            out_ready_i,
  output md5_pkg::status_t     status_o,
  output logic                 out_valid_o,
  output logic [127:0]         out_data_o
);
  import md5_pkg::*;

  logic [31:0]  block_q [NUM_WORDS];
  logic [31:0]  chain_q [4];
  logic [31:0]  chain_d [4];
  logic [31:0]  work_q  [4];   // A B C D
  logic [31:0]  work_d  [4];
  logic [31:0]  kw_q, kw_d;
  logic [31:0]  rsum;
  logic [31:0]  sum_fold [4];
  logic         out_valid_q, out_valid_d;
  logic [127:0] out_data_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sum_fold[i] = chain_q[i] + work_q[i];
    end
  end

  // round step; K + M already sits in kw_q
  assign rsum = work_q[0] + round_f(cmd_i.round, work_q[1], work_q[2], work_q[3]) + kw_q;

  always_comb begin
    work_d = work_q;
    if (cmd_i.init_work) begin
      work_d = chain_q;
    end else if (cmd_i.do_round) begin
      work_d[0] = work_q[3];
      work_d[3] = work_q[2];
      work_d[2] = work_q[1];
      work_d[1] = work_q[1] + rotl32(rsum, ROT_S[{cmd_i.round[5:4], cmd_i.round[1:0]}]);
    end
  end

  assign kw_d = ROUND_K[cmd_i.kw_round] + block_q[msg_index(cmd_i.kw_round)];

  always_comb begin
    chain_d = chain_q;
    if (cmd_i.load_word && cmd_i.start_iv) begin
      chain_d = IV;
    end else if (cmd_i.finish) begin
      chain_d = sum_fold;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q     <= IV;
      out_valid_q <= 1'b0;
    end else begin
      chain_q     <= chain_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_word) begin
      block_q[cmd_i.word_idx] <= word_i;
    end
    if (cmd_i.kw_load) begin
      kw_q <= kw_d;
    end
    work_q <= work_d;
    if (cmd_i.finish) begin
      out_data_q <= {sum_fold[3], sum_fold[2], sum_fold[1], sum_fold[0]};
    end
  end

  assign status_o.out_busy = out_valid_q;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_data_q;

endmodule

`default_nettype wire

[design/md5_ctrl.sv]
// Controller: word counter, round counter and sequencing state machine.
`default_nettype none

module md5_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_start_i,
  output logic                   in_ready_o,
  input  wire logic              out_ready_i,
  input  wire md5_pkg::status_t  status_i,
  output md5_pkg::cmd_t          cmd_o
);
  import md5_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_ROUND  = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

  localparam word_idx_t LAST_WORD  = word_idx_t'(NUM_WORDS - 1);
  localparam round_t    LAST_ROUND = round_t'(NUM_ROUNDS - 1);

  state_e    state_q, state_d;
  word_idx_t count_q, count_d;
  round_t    round_q, round_d;
  word_idx_t idx;

  assign idx = in_start_i ? '0 : count_q;

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    round_d    = round_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.round = round_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_word = 1'b1;
          cmd_o.word_idx  = idx;
          cmd_o.start_iv  = in_start_i;
          count_d         = idx + 4'd1;
          if (idx == LAST_WORD) begin
            cmd_o.init_work = 1'b1;
            cmd_o.kw_load   = 1'b1;
            cmd_o.kw_round  = '0;
            round_d         = '0;
            state_d         = ST_ROUND;
          end
        end
      end
      ST_ROUND: begin
        cmd_o.do_round = 1'b1;
        cmd_o.kw_load  = 1'b1;
        cmd_o.kw_round = round_q + 6'd1;
        round_d        = round_q + 6'd1;
        if (round_q == LAST_ROUND) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold until the result register is free
        if (!status_i.out_busy || out_ready_i) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      round_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      round_q <= round_d;
    end
  end

endmodule

`default_nettype wire

[design/md5_block_compression_unit.sv]
// Top level: MD5 block compression unit with stream input and output.
`default_nettype none

`include "md5_block_compression_unit_macros.svh"

// MD5 compression over 512-bit blocks fed as sixteen 32-bit little-endian
// message words, one per input beat. A beat with tuser set starts a new
// message: the chaining value is reset to the MD5 IV and the beat becomes
// word 0 (any partial block is dropped). After the sixteenth word the unit
// runs the 64 rounds on one shared round unit, one round per clock, folds
// A..D into the chaining value and presents the new chaining value as one
// output beat. Blocks without tuser chain from the previous result. Input
// is held off (s_axis_tready_o low) while rounds run and until the fold, so
// a block takes its 16 input beats, then the 64 rounds one after another on
// the single-round datapath, then the fold. The result sits in an output
// register; input beats of the next block are taken while it waits, and
// only the fold of the next block waits for it to be taken. Padding and
// length append are done by software.

module md5_block_compression_unit (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // input stream
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [31:0]  s_axis_tdata_i,   // [31:0] message_word
  input  wire logic         s_axis_tuser_i,   // [0] start_message
  // output stream
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  output logic [127:0]      m_axis_tdata_o    // [63:0] digest_ab, [127:64] digest_cd
);
  import md5_pkg::*;

  cmd_t    cmd;
  status_t status;

  md5_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_start_i  (s_axis_tuser_i),
    .in_ready_o  (s_axis_tready_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  md5_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .word_i      (s_axis_tdata_i),
    .out_ready_i (m_axis_tready_i),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (m_axis_tdata_o)
  );

  // at most one of word load, round step and fold in any cycle
  `MD5_ASSERT_ALWAYS(a_cmd_exclusive, clk_i, rst_ni, $onehot0({cmd.load_word, cmd.do_round, cmd.finish}))
  // no input beat is taken while rounds run
  `MD5_ASSERT_IMPLIES(a_no_input_in_rounds, clk_i, rst_ni, cmd.do_round, !s_axis_tready_o)
  // a fold never overwrites a result that has not been taken
  `MD5_ASSERT_IMPLIES(a_no_result_overwrite, clk_i, rst_ni, cmd.finish, !status.out_busy || m_axis_tready_i)
  // a fold always presents a result beat next cycle
  `MD5_ASSERT_NEXT(a_fold_gives_beat, clk_i, rst_ni, cmd.finish, m_axis_tvalid_o)

endmodule

`default_nettype wire
